// ----- sv/sqe_pkg.sv -----
package sqe_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_LEARN_RATE = 3'd0;
  localparam logic [2:0] REG_DISCOUNT   = 3'd1;
  localparam logic [2:0] REG_EXPLORE    = 3'd2;
  localparam logic [2:0] REG_WINDOW     = 3'd3;
  localparam logic [2:0] REG_SEED       = 3'd4;

  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam logic [15:0] RESET_SEED = 16'd44257;

  // Request codes
  localparam logic REQ_CHOOSE = 1'b0;
  localparam logic REQ_LEARN  = 1'b1;

  // One Galois LFSR step, shifting right
  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    logic [15:0] n;
    n = v >> 1;
    if (v[0]) n = n ^ LFSR_TAPS;
    return n;
  endfunction

  // Shared arithmetic unit operations
  typedef enum logic [1:0] {
    OP_MUL_GAMMA,
    OP_MUL_ALPHA,
    OP_CMP
  } alu_op_e;

  typedef struct packed {
    alu_op_e     op;
    logic [15:0] coef;
  } alu_ctl_t;

endpackage

// ----- sv/sqe_alu.sv -----
// Shared unit: signed 34x17 multiply with floor shift by 16, or a signed compare.
module sqe_alu (
  input  logic                 clk_i,
  input  sqe_pkg::alu_ctl_t    ctl_i,
  input  logic signed [33:0]   a_i,
  input  logic signed [31:0]   b_i,
  output logic signed [33:0]   prod_o,
  output logic                 gt_o
);
  import sqe_pkg::*;

  logic signed [50:0] prod_full;
  logic signed [33:0] prod_q;

  // Arithmetic shift right drops bits, i.e. rounds toward minus infinity
  always_comb begin
    prod_full = 51'(a_i) * 51'(signed'({1'b0, ctl_i.coef}));
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 34'(prod_full >>> 16);
  end

  assign prod_o = prod_q;
  assign gt_o   = (ctl_i.op == OP_CMP) && (a_i > 34'(b_i));
endmodule

// ----- sv/sarsa_qtable_engine_top.sv -----
// Channel  | signals                                            | direction
// input    | in_valid_i, in_stall_o, req_type_i..next_action_i  | in
// result   | out_valid_o, out_stall_i, chosen_action_o..saturated_o | out
// config   | cfg_we_i, cfg_index_i, cfg_data_i                  | in
// Choose: explore or exploit (the exploit scan does one table read per cycle).
// Learn: two table reads, two multiplies through the shared unit, write.
// After reset a clearing pass writes INIT_Q over every table entry;
// no transaction is accepted meanwhile. Input is taken only while idle; the result
// register holds while out_stall_i is high, and the next input may then already run.
module sarsa_qtable_engine_top #(
  parameter int STATES  = 1024,
  parameter int ACTIONS = 16,
  parameter int INIT_Q  = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [9:0]  cur_state_i,
  input  logic [3:0]  cur_action_i,
  input  logic signed [15:0] reward_i,
  input  logic [9:0]  next_state_i,
  input  logic [3:0]  next_action_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  chosen_action_o,
  output logic        explored_o,
  output logic signed [31:0] updated_q_o,
  output logic        saturated_o
);
  import sqe_pkg::*;

  localparam int SW    = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int AW    = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;
  localparam int DEPTH = STATES * ACTIONS;
  localparam int IW    = $clog2(DEPTH);
  localparam logic [IW:0] LAST = (IW + 1)'(DEPTH - 1);
  localparam logic [AW:0] LAST_A = (AW + 1)'(ACTIONS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXPL, S_SCAN, S_SCAN_END,
    S_RD2, S_GMUL, S_DIFF, S_AMUL, S_WR, S_OUT
  } state_e;

  // Configuration registers
  logic [15:0] alpha_q, gamma_q, thresh_q, lfsr_q;
  logic [31:0] window_q, count_q;

  // Table memory
  logic signed [31:0] mem [DEPTH];
  logic        rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic signed [31:0] wr_data, rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  state_e state_q;
  logic [IW:0]  clr_q;
  logic         req_q;
  logic [SW-1:0] s1_q, s2_q;
  logic [AW-1:0] a1_q, a2_q, best_a_q;
  logic [AW:0]   k_q;
  logic signed [15:0] rew_q;
  logic signed [31:0] q1_q, best_q;
  logic signed [33:0] acc_q;
  logic [3:0]  act_q;
  logic        expl_q;
  logic        out_valid_q, sat_q;
  logic signed [31:0] uq_q;

  // Shared unit
  alu_ctl_t ctl;
  logic signed [33:0] alu_a, prod;
  logic signed [31:0] alu_b;
  logic gt;

  sqe_alu u_alu (
    .clk_i (clk_i), .ctl_i (ctl), .a_i (alu_a), .b_i (alu_b),
    .prod_o (prod), .gt_o (gt)
  );

  always_comb begin
    ctl.op   = OP_CMP;
    ctl.coef = gamma_q;
    alu_a    = 34'(rd_q);
    alu_b    = best_q;
    unique case (state_q)
      S_GMUL: begin ctl.op = OP_MUL_GAMMA; ctl.coef = gamma_q; end
      S_AMUL: begin ctl.op = OP_MUL_ALPHA; ctl.coef = alpha_q; alu_a = acc_q; end
      default: ;
    endcase
  end

  logic accept_in, out_free;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  logic [15:0] d1;
  assign d1 = lfsr_next(lfsr_q);

  // Q1 + delta, valid while the scaled delta sits in the unit output
  logic signed [33:0] nq;
  logic signed [31:0] nq_sat;
  logic               nq_clamp;
  assign nq = 34'(q1_q) + prod;

  // Clamp to 32 bits
  always_comb begin
    nq_sat   = 32'(nq);
    nq_clamp = 1'b0;
    if (nq > 34'sd2147483647) begin
      nq_sat   = 32'h7FFFFFFF;
      nq_clamp = 1'b1;
    end else if (nq < -34'sd2147483648) begin
      nq_sat   = 32'h80000000;
      nq_clamp = 1'b1;
    end
  end

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = clr_q[IW-1:0];
    wr_data = 32'(INIT_Q);
    unique case (state_q)
      S_CLEAR: wr_en = 1'b1;
      S_IDLE: begin
        rd_en = accept_in;
        rd_addr = (req_type_i == REQ_LEARN) ?
          IW'(32'(cur_state_i) % STATES * ACTIONS + 32'(cur_action_i) % ACTIONS) :
          IW'(32'(cur_state_i) % STATES * ACTIONS);
      end
      S_SCAN: begin
        rd_en = 1'b1;
        rd_addr = IW'(32'(s1_q) * ACTIONS + 32'(k_q[AW-1:0]));
      end
      S_RD2: begin
        rd_en = 1'b1;
        rd_addr = IW'(32'(s2_q) * ACTIONS + 32'(a2_q));
      end
      S_WR: begin
        wr_en = 1'b1;
        wr_addr = IW'(32'(s1_q) * ACTIONS + 32'(a1_q));
        wr_data = nq_sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      alpha_q <= 16'd426;
      gamma_q <= 16'd36438;
      thresh_q <= 16'd131;
      window_q <= '0;
      lfsr_q <= RESET_SEED;
      count_q <= '0;
      out_valid_q <= 1'b0;
      k_q <= '0;
      req_q <= 1'b0;
      expl_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_OUT) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_LEARN_RATE: alpha_q <= cfg_data_i[15:0];
          REG_DISCOUNT:   gamma_q <= cfg_data_i[15:0];
          REG_EXPLORE:    thresh_q <= cfg_data_i[15:0];
          REG_WINDOW:     window_q <= cfg_data_i;
          REG_SEED:       lfsr_q <= (cfg_data_i[15:0] == '0) ? 16'd1 : cfg_data_i[15:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LAST) state_q <= S_IDLE;
        end
        S_IDLE: if (accept_in) begin
          req_q <= req_type_i;
          s1_q <= SW'(32'(cur_state_i) % STATES);
          s2_q <= SW'(32'(next_state_i) % STATES);
          a1_q <= AW'(32'(cur_action_i) % ACTIONS);
          a2_q <= AW'(32'(next_action_i) % ACTIONS);
          rew_q <= reward_i;
          if (req_type_i == REQ_LEARN) begin
            state_q <= S_RD2;
          end else begin
            if (count_q < window_q) begin
              count_q <= count_q + 1'b1;
              state_q <= S_EXPL;
            end else begin
              lfsr_q <= d1;
              state_q <= (d1 < thresh_q) ? S_EXPL : S_SCAN;
            end
            k_q <= (AW + 1)'(1);
          end
        end
        S_EXPL: begin
          lfsr_q <= d1;
          act_q <= 4'(32'(d1) % ACTIONS);
          expl_q <= 1'b1;
          state_q <= S_OUT;
        end
        S_SCAN: begin
          // k_q is one read ahead of rd_q
          if (k_q == (AW + 1)'(1)) begin
            best_q <= rd_q;
            best_a_q <= '0;
          end else if (gt) begin
            best_q <= rd_q;
            best_a_q <= AW'(k_q - 1'b1);
          end
          if (k_q == LAST_A) state_q <= S_SCAN_END;
          k_q <= k_q + 1'b1;
        end
        S_SCAN_END: begin
          expl_q <= 1'b0;
          act_q <= 4'((gt && ACTIONS > 1) ? AW'(LAST_A) : best_a_q);
          state_q <= S_OUT;
        end
        S_RD2: begin
          q1_q <= rd_q;
          state_q <= S_GMUL;
        end
        S_GMUL: state_q <= S_DIFF;
        S_DIFF: begin
          acc_q <= (34'(rew_q) <<< 16) + prod - 34'(q1_q);
          state_q <= S_AMUL;
        end
        S_AMUL: state_q <= S_WR;
        S_WR: begin
          state_q <= S_OUT;
          expl_q <= 1'b0;
          act_q <= '0;
        end
        S_OUT: if (out_free) begin
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Saturated result, taken while the table entry is written
  always_ff @(posedge clk_i) begin
    if (state_q == S_WR) begin
      uq_q  <= nq_sat;
      sat_q <= nq_clamp;
    end
  end

  logic [3:0] o_act_q;
  logic o_expl_q, o_sat_q;
  logic signed [31:0] o_uq_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      o_act_q  <= act_q;
      o_expl_q <= expl_q;
      o_uq_q   <= req_q ? uq_q : 32'sd0;
      o_sat_q  <= req_q ? sat_q : 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_action_o = o_act_q;
  assign explored_o      = o_expl_q;
  assign updated_q_o     = o_uq_q;
  assign saturated_o     = o_sat_q;

  // No input accepted during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> in_stall_o) else $error("input taken while clearing");
  // LFSR never reaches zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0) else $error("lfsr locked");
  // Choice count steps by one on each choice taken while below the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && accept_in && !req_type_i && count_q < window_q)
      |=> count_q == $past(count_q) + 1) else $error("count step");
endmodule
